// ===== rtl/trc_pkg.sv =====
// Package for the tandem repeat unit counter.
// Holds the word types of both channels, segment codes, default sizes and
// the control and status structs between the top level and the sequencer.
package trc_pkg;

    localparam int MAX_ALLELE_LEN  = 64;
    localparam int MAX_CONTEXT_LEN = 256;

    localparam logic [1:0] SEG_REF    = 2'd0;
    localparam logic [1:0] SEG_ALT    = 2'd1;
    localparam logic [1:0] SEG_CTX    = 2'd2;
    localparam logic [1:0] SEG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] base;
        logic [1:0] segment;
        logic       has_base;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [6:0] unit_length;
        logic       unit_from_alt;
        logic [8:0] ref_repeats;
        logic [9:0] alt_repeats;
        logic       is_tandem;
        logic       error;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic ack;
    } seq_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

// ===== rtl/tandem_repeat_unit_counter.sv =====
// Tandem repeat unit counter. Loading takes one word per cycle while the
// sequencer is idle. After the word marked last, the sequencer finds the
// unit and then walks the stores: every byte compare has an issue state
// that presents addresses to the registered-read RAMs and a compare state.
// The search runs at most n*(n-1)/2 compares for the longer allele length n.
// Reset (aresetn, synchronous, active low) clears counts and control only.
module tandem_repeat_unit_counter #(
    parameter int MAX_ALLELE_LEN  = trc_pkg::MAX_ALLELE_LEN,
    parameter int MAX_CONTEXT_LEN = trc_pkg::MAX_CONTEXT_LEN
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  trc_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output trc_pkg::out_word_t m_data
);

    localparam int AW  = (MAX_ALLELE_LEN > 1) ? $clog2(MAX_ALLELE_LEN) : 1;
    localparam int CAW = (MAX_CONTEXT_LEN > 1) ? $clog2(MAX_CONTEXT_LEN) : 1;
    localparam int CNW = $clog2(MAX_ALLELE_LEN + 1);
    localparam int CCW = $clog2(MAX_CONTEXT_LEN + 1);

    // Fill counts of the three stores and the sticky overflow flag.
    logic [CNW-1:0] ref_count_reg, ref_count_next;
    logic [CNW-1:0] alt_count_reg, alt_count_next;
    logic [CCW-1:0] ctx_count_reg, ctx_count_next;
    logic           overflow_reg, overflow_next;

    logic               m_valid_reg;
    trc_pkg::out_word_t m_data_reg;

    trc_pkg::seq_ctrl_t ctrl;
    trc_pkg::seq_stat_t stat;
    trc_pkg::out_word_t result;

    logic           accept;
    logic           ref_we, alt_we, ctx_we;
    logic [AW-1:0]  a_addr, b_addr;
    logic [CAW-1:0] c_addr;
    logic [7:0]     ref_a, alt_a, ref_b, alt_b, ctx_b;

    // New words are taken only while the sequencer is idle; a finished
    // result may still sit in the output register meanwhile.
    assign s_ready = stat.idle;
    assign accept  = s_valid && s_ready;

    assign ref_we = accept && s_data.has_base && s_data.segment == trc_pkg::SEG_REF
                    && ref_count_reg < CNW'(MAX_ALLELE_LEN);
    assign alt_we = accept && s_data.has_base && s_data.segment == trc_pkg::SEG_ALT
                    && alt_count_reg < CNW'(MAX_ALLELE_LEN);
    assign ctx_we = accept && s_data.has_base && s_data.segment == trc_pkg::SEG_CTX
                    && ctx_count_reg < CCW'(MAX_CONTEXT_LEN);

    assign ctrl.start = accept && s_data.last;
    assign ctrl.ack   = stat.done && (!m_valid_reg || m_ready);

    always_comb begin
        ref_count_next = ref_count_reg;
        alt_count_next = alt_count_reg;
        ctx_count_next = ctx_count_reg;
        overflow_next  = overflow_reg;
        if (ctrl.ack) begin
            // The set is consumed: start the next one empty.
            ref_count_next = '0;
            alt_count_next = '0;
            ctx_count_next = '0;
            overflow_next  = 1'b0;
        end else if (accept && s_data.has_base) begin
            unique case (s_data.segment)
                trc_pkg::SEG_REF: begin
                    if (ref_we) begin
                        ref_count_next = ref_count_reg + CNW'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                trc_pkg::SEG_ALT: begin
                    if (alt_we) begin
                        alt_count_next = alt_count_reg + CNW'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                trc_pkg::SEG_CTX: begin
                    if (ctx_we) begin
                        ctx_count_next = ctx_count_reg + CCW'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                default: begin
                    // Unused segment code: the base is ignored.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_count_reg <= '0;
            alt_count_reg <= '0;
            ctx_count_reg <= '0;
            overflow_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            ref_count_reg <= ref_count_next;
            alt_count_reg <= alt_count_next;
            ctx_count_reg <= ctx_count_next;
            overflow_reg  <= overflow_next;
            if (ctrl.ack) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (ctrl.ack) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    trc_ram #(.WIDTH(8), .DEPTH(MAX_ALLELE_LEN)) u_ref_ram (
        .aclk      (aclk),
        .we        (ref_we),
        .wr_addr   (ref_count_reg[AW-1:0]),
        .wr_data   (s_data.base),
        .rd_a_addr (a_addr),
        .rd_a_data (ref_a),
        .rd_b_addr (b_addr),
        .rd_b_data (ref_b)
    );

    trc_ram #(.WIDTH(8), .DEPTH(MAX_ALLELE_LEN)) u_alt_ram (
        .aclk      (aclk),
        .we        (alt_we),
        .wr_addr   (alt_count_reg[AW-1:0]),
        .wr_data   (s_data.base),
        .rd_a_addr (a_addr),
        .rd_a_data (alt_a),
        .rd_b_addr (b_addr),
        .rd_b_data (alt_b)
    );

    // The context store is read on one port only.
    trc_ram #(.WIDTH(8), .DEPTH(MAX_CONTEXT_LEN)) u_ctx_ram (
        .aclk      (aclk),
        .we        (ctx_we),
        .wr_addr   (ctx_count_reg[CAW-1:0]),
        .wr_data   (s_data.base),
        .rd_a_addr (c_addr),
        .rd_a_data (),
        .rd_b_addr (c_addr),
        .rd_b_data (ctx_b)
    );

    trc_seq #(
        .MAX_ALLELE_LEN  (MAX_ALLELE_LEN),
        .MAX_CONTEXT_LEN (MAX_CONTEXT_LEN)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .ref_count (ref_count_reg),
        .alt_count (alt_count_reg),
        .ctx_count (ctx_count_reg),
        .overflow  (overflow_reg),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .c_addr    (c_addr),
        .ref_a     (ref_a),
        .alt_a     (alt_a),
        .ref_b     (ref_b),
        .alt_b     (alt_b),
        .ctx_b     (ctx_b),
        .result    (result)
    );

    // A last word hands the set to the sequencer, so loading pauses.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> !s_ready)
        else $error("input taken while a set is being computed");

    // A result is only committed when the output register has room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("pending result word overwritten");

    // Error words carry no unit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.unit_length == '0 && !m_data.is_tandem)
        else $error("error word with nonzero fields");

    // Allele fill counts never pass their store sizes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ref_count_reg <= CNW'(MAX_ALLELE_LEN) && alt_count_reg <= CNW'(MAX_ALLELE_LEN))
        else $error("allele fill count beyond store");

endmodule

// ===== rtl/trc_ram.sv =====
// Generic RAM: one write port and two read ports, read data registered.
// Uses no package.
module trc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]                      rd_a_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]                      rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ===== rtl/trc_seq.sv =====
// Compute sequencer: finds the repeat unit and counts leading copies by
// walking the three stores one byte compare at a time. Depends on trc_pkg.
module trc_seq #(
    parameter int MAX_ALLELE_LEN  = trc_pkg::MAX_ALLELE_LEN,
    parameter int MAX_CONTEXT_LEN = trc_pkg::MAX_CONTEXT_LEN,
    localparam int AW  = (MAX_ALLELE_LEN > 1) ? $clog2(MAX_ALLELE_LEN) : 1,
    localparam int CAW = (MAX_CONTEXT_LEN > 1) ? $clog2(MAX_CONTEXT_LEN) : 1,
    localparam int CNW = $clog2(MAX_ALLELE_LEN + 1),
    localparam int CCW = $clog2(MAX_CONTEXT_LEN + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  trc_pkg::seq_ctrl_t  ctrl,
    output trc_pkg::seq_stat_t  stat,
    input  logic [CNW-1:0]      ref_count,
    input  logic [CNW-1:0]      alt_count,
    input  logic [CCW-1:0]      ctx_count,
    input  logic                overflow,
    output logic [AW-1:0]       a_addr,
    output logic [AW-1:0]       b_addr,
    output logic [CAW-1:0]      c_addr,
    input  logic [7:0]          ref_a,
    input  logic [7:0]          alt_a,
    input  logic [7:0]          ref_b,
    input  logic [7:0]          alt_b,
    input  logic [7:0]          ctx_b,
    output trc_pkg::out_word_t  result
);

    localparam int LW = $clog2(MAX_ALLELE_LEN + 2);
    localparam int JW = $clog2(MAX_ALLELE_LEN + MAX_CONTEXT_LEN + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_U_ISS = 7'b0000100,
        S_U_CMP = 7'b0001000,
        S_C_ISS = 7'b0010000,
        S_C_CMP = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic            err_reg, err_next;
    logic            pass_reg, pass_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   pos_reg, pos_next;
    logic [LW-1:0]   k_reg, k_next;
    logic [JW-1:0]   j_reg, j_next;
    logic [JW-1:0]   copies_reg, copies_next;
    logic [JW-1:0]   in_ref_reg, in_ref_next;
    logic [JW-1:0]   ref_ctx_reg, ref_ctx_next;
    logic [JW-1:0]   alt_ctx_reg, alt_ctx_next;

    logic            from_alt;
    logic [CNW-1:0]  n_long;
    logic [CNW-1:0]  alen;
    logic [JW-1:0]   total;
    logic            in_allele;
    logic [7:0]      unit_a;
    logic [7:0]      unit_b;
    logic [7:0]      walk_byte;
    logic [LW-1:0]   back_pos;
    logic [JW-1:0]   ctx_pos;
    logic            pass_end;
    logic [31:0]     len_w;
    logic [31:0]     ref_diff;
    logic [31:0]     alt_diff;

    assign from_alt  = alt_count > ref_count;
    assign n_long    = from_alt ? alt_count : ref_count;
    assign alen      = pass_reg ? alt_count : ref_count;
    assign total     = JW'(alen) + JW'(ctx_count);
    assign in_allele = j_reg < JW'(alen);
    assign unit_a    = from_alt ? alt_a : ref_a;
    assign unit_b    = from_alt ? alt_b : ref_b;
    assign walk_byte = in_allele ? (pass_reg ? alt_b : ref_b) : ctx_b;
    assign back_pos  = pos_reg - len_reg;
    assign ctx_pos   = j_reg - JW'(alen);

    // The search compares each byte with the one a unit length back; the
    // walk compares the joined string against repeated copies of the unit.
    always_comb begin
        if (state_reg == S_U_ISS) begin
            a_addr = back_pos[AW-1:0];
            b_addr = pos_reg[AW-1:0];
        end else begin
            a_addr = k_reg[AW-1:0];
            b_addr = j_reg[AW-1:0];
        end
        c_addr = ctx_pos[CAW-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        err_next     = err_reg;
        pass_next    = pass_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        copies_next  = copies_reg;
        in_ref_next  = in_ref_reg;
        ref_ctx_next = ref_ctx_reg;
        alt_ctx_next = alt_ctx_reg;
        pass_end     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (ctrl.start) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                err_next = overflow || (ref_count == '0 && alt_count == '0);
                len_next = LW'(1);
                pos_next = LW'(1);
                k_next   = '0;
                state_next = (overflow || (ref_count == '0 && alt_count == '0))
                             ? S_DONE : S_U_ISS;
            end
            S_U_ISS: begin
                if (pos_reg >= LW'(n_long)) begin
                    if (k_reg == '0) begin
                        pass_next   = 1'b0;
                        j_next      = '0;
                        k_next      = '0;
                        copies_next = '0;
                        in_ref_next = '0;
                        state_next  = S_C_ISS;
                    end else begin
                        len_next = len_reg + LW'(1);
                        pos_next = len_reg + LW'(1);
                        k_next   = '0;
                    end
                end else begin
                    state_next = S_U_CMP;
                end
            end
            S_U_CMP: begin
                if (unit_a == unit_b) begin
                    pos_next = pos_reg + LW'(1);
                    k_next   = (k_reg + LW'(1) == len_reg) ? '0 : k_reg + LW'(1);
                end else begin
                    len_next = len_reg + LW'(1);
                    pos_next = len_reg + LW'(1);
                    k_next   = '0;
                end
                state_next = S_U_ISS;
            end
            S_C_ISS: begin
                if (!pass_reg && j_reg == JW'(alen)) begin
                    in_ref_next = copies_reg;
                end
                if (j_reg >= total) begin
                    pass_end = 1'b1;
                end else begin
                    state_next = S_C_CMP;
                end
            end
            S_C_CMP: begin
                if (walk_byte == unit_a) begin
                    j_next = j_reg + JW'(1);
                    if (k_reg + LW'(1) == len_reg) begin
                        k_next      = '0;
                        copies_next = copies_reg + JW'(1);
                    end else begin
                        k_next = k_reg + LW'(1);
                    end
                    state_next = S_C_ISS;
                end else begin
                    pass_end = 1'b1;
                end
            end
            S_DONE: begin
                if (ctrl.ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (pass_end) begin
            if (!pass_reg) begin
                ref_ctx_next = copies_reg;
                if (in_allele) begin
                    in_ref_next = copies_reg;
                end
                pass_next   = 1'b1;
                j_next      = '0;
                k_next      = '0;
                copies_next = '0;
                state_next  = S_C_ISS;
            end else begin
                alt_ctx_next = copies_reg;
                state_next   = S_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        err_reg     <= err_next;
        pass_reg    <= pass_next;
        len_reg     <= len_next;
        pos_reg     <= pos_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        copies_reg  <= copies_next;
        in_ref_reg  <= in_ref_next;
        ref_ctx_reg <= ref_ctx_next;
        alt_ctx_reg <= alt_ctx_next;
    end

    assign len_w    = 32'(len_reg);
    assign ref_diff = 32'(ref_ctx_reg) - 32'(in_ref_reg);
    assign alt_diff = 32'(alt_ctx_reg) - 32'(in_ref_reg);

    always_comb begin
        if (err_reg) begin
            result       = '0;
            result.error = 1'b1;
        end else begin
            result.unit_length   = len_w[6:0];
            result.unit_from_alt = from_alt;
            result.ref_repeats   = ref_diff[8:0];
            result.alt_repeats   = alt_diff[9:0];
            result.is_tandem     = (ref_diff != '0) && (alt_diff != '0);
            result.error         = 1'b0;
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);

endmodule
